// ----- rtl/srle_pkg.sv -----
// ---------------------------------------------------------------------------
// srle_pkg
// Shared types, constants and the default instrument pattern for the song block RLE decoder.
// ---------------------------------------------------------------------------
package srle_pkg;

   localparam int OFFSET_BITS = 24;
   localparam int PATTERN_LEN = 16;
   localparam int PIDX_BITS   = $clog2(PATTERN_LEN);
   localparam logic [15:0] SONG_SIZE = 16'd32768;
   localparam logic [15:0] COUNT_MAX = 16'hFFFF;

   // escape and command codes of the compressed stream
   localparam logic [7:0] BYTE_RLE  = 8'hC0;
   localparam logic [7:0] BYTE_SPEC = 8'hE0;
   localparam logic [7:0] BYTE_WAVE = 8'hF0;
   localparam logic [7:0] BYTE_INST = 8'hF1;
   localparam logic [7:0] BYTE_EOF  = 8'hFF;

   // configuration register indexes
   localparam int CSR_IDX_BITS = 3;
   localparam logic [CSR_IDX_BITS-1:0] CSR_ABS_MODE   = 3'd0;
   localparam logic [CSR_IDX_BITS-1:0] CSR_FIRST_OFF  = 3'd1;
   localparam logic [CSR_IDX_BITS-1:0] CSR_BLOCK_SIZE = 3'd2;
   localparam logic [CSR_IDX_BITS-1:0] CSR_START_OFF  = 3'd3;
   localparam logic [CSR_IDX_BITS-1:0] CSR_WAVE_LO    = 3'd4;
   localparam logic [CSR_IDX_BITS-1:0] CSR_WAVE_HI    = 3'd5;

   typedef enum logic [2:0] {
      PH_IDLE,
      PH_RUN_VAL,
      PH_RUN_CNT,
      PH_ESC,
      PH_WAVE_CNT,
      PH_INST_CNT
   } phase_type;

   typedef enum logic [1:0] {
      EX_NONE,
      EX_RUN,
      EX_WAVE,
      EX_INST
   } expand_type;

   typedef enum logic [1:0] {
      KIND_DATA,
      KIND_SEEK,
      KIND_END,
      KIND_ERROR
   } kind_type;

   typedef struct packed {
      logic       is_tick;
      logic [7:0] data;
   } item_type;

   typedef struct packed {
      kind_type               kind;
      logic [7:0]             data;
      logic [OFFSET_BITS-1:0] seek;
      logic                   size_ok;
      logic                   more;
   } result_type;

   // fixed default instrument
   function automatic logic [7:0] inst_byte(input logic [PIDX_BITS-1:0] idx);
      logic [7:0] val;
      case (idx)
         4'd0:    val = 8'hA8;
         4'd3:    val = 8'hFF;
         4'd6:    val = 8'h03;
         4'd9:    val = 8'hD0;
         4'd13:   val = 8'hF3;
         default: val = 8'h00;
      endcase
      return val;
   endfunction

endpackage

// ----- rtl/song_block_rle_decompressor.sv -----
// ---------------------------------------------------------------------------
// song_block_rle_decompressor
// Run-length decoder for compressed song blocks, with drain ticks for
// queued run, wave and instrument expansions and seek/end reporting.
// ---------------------------------------------------------------------------
//
//   channel  direction  handshake              payload
//   req      in         req_valid/req_ready    req_type, req_in_byte
//   rsp      out        rsp_valid/rsp_ready    kind, byte, seek, size_ok, more
//   csr      in         csr_we (no wait)       csr_index, csr_wdata
//
// One transfer per cycle sustained while results are taken. A request is held in
// the input register, is decoded in one pass and its result (if any) lands in the
// result register; the rate is set by the parser state loop, whose
// longest path is the 24x16 block seek multiply and add.
// Reset is synchronous; no clearing pass is needed.
// A stalled result holds the decode stage; the input register then fills
// and req_ready drops until the result is taken.
// ---------------------------------------------------------------------------
module song_block_rle_decompressor (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic                              req_type,
   input  logic [7:0]                        req_in_byte,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [1:0]                        rsp_out_kind,
   output logic [7:0]                        rsp_out_byte,
   output logic [srle_pkg::OFFSET_BITS-1:0]  rsp_seek_offset,
   output logic                              rsp_size_ok,
   output logic                              rsp_more_pending,
   input  logic                              csr_we,
   input  logic [srle_pkg::CSR_IDX_BITS-1:0] csr_index,
   input  logic [63:0]                       csr_wdata
);

   logic                 item_vld;
   srle_pkg::item_type   item;
   logic                 out_free;
   logic                 advance;
   logic                 res_vld;
   srle_pkg::result_type res;

   // the decode stage moves whenever it holds an item and the result slot
   // is free or being emptied this cycle
   assign advance = item_vld && out_free;

   srle_in_stage u_in (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_type    (req_type),
      .req_in_byte (req_in_byte),
      .advance     (advance),
      .item_vld    (item_vld),
      .item        (item)
   );

   srle_core u_core (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .advance   (advance),
      .item      (item),
      .res_vld   (res_vld),
      .res       (res)
   );

   // items that produce nothing (escape prefixes, idle drain ticks) just retire
   srle_out_stage u_out (
      .clock            (clock),
      .reset            (reset),
      .load             (advance && res_vld),
      .res              (res),
      .out_free         (out_free),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_out_kind     (rsp_out_kind),
      .rsp_out_byte     (rsp_out_byte),
      .rsp_seek_offset  (rsp_seek_offset),
      .rsp_size_ok      (rsp_size_ok),
      .rsp_more_pending (rsp_more_pending)
   );

endmodule

// ----- rtl/srle_in_stage.sv -----
// ---------------------------------------------------------------------------
// srle_in_stage
// Request register: holds one accepted transfer for the decode stage.
// ---------------------------------------------------------------------------
module srle_in_stage (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic               req_type,
   input  logic [7:0]         req_in_byte,
   input  logic               advance,
   output logic               item_vld,
   output srle_pkg::item_type item
);

   logic               vld_ff, vld_in;
   srle_pkg::item_type item_ff;

   assign req_ready = !vld_ff || advance;
   assign vld_in    = (req_valid && req_ready) ? 1'b1 : (advance ? 1'b0 : vld_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         item_ff.is_tick <= req_type;
         item_ff.data    <= req_in_byte;
      end
   end

   assign item_vld = vld_ff;
   assign item     = item_ff;

endmodule

// ----- rtl/srle_core.sv -----
// ---------------------------------------------------------------------------
// srle_core
// Configuration registers, parser state and single-pass decode of one item.
// ---------------------------------------------------------------------------
module srle_core (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_we,
   input  logic [srle_pkg::CSR_IDX_BITS-1:0]    csr_index,
   input  logic [63:0]                          csr_wdata,
   input  logic                                 advance,
   input  srle_pkg::item_type                   item,
   output logic                                 res_vld,
   output srle_pkg::result_type                 res
);

   localparam int OB = srle_pkg::OFFSET_BITS;
   localparam int PB = srle_pkg::PIDX_BITS;

   // configuration
   logic          abs_mode_ff;
   logic [OB-1:0] first_off_ff;
   logic [15:0]   block_size_ff;
   logic [OB-1:0] start_off_ff;
   logic [63:0]   wave_lo_ff, wave_hi_ff;

   // parser state
   srle_pkg::phase_type  phase_ff, phase_in;
   srle_pkg::expand_type expand_ff, expand_in;
   logic [7:0]    reps_ff, reps_in;
   logic [PB-1:0] pidx_ff, pidx_in;
   logic [7:0]    run_ff, run_in;
   logic [OB-1:0] rpos_ff, rpos_in;
   logic [15:0]   count_ff, count_in;

   logic          pending;
   logic [15:0]   count_inc;
   logic [127:0]  wave_all;
   logic [7:0]    pat_byte;
   logic [PB-1:0] pidx_next;
   logic [OB-1:0] block_idx;
   logic [OB+15:0] block_prod;
   logic [OB-1:0] seek_abs, seek_rel;
   logic [7:0]    b;

   assign b         = item.data;
   assign pending   = (expand_ff != srle_pkg::EX_NONE) && (reps_ff != 8'd0);
   assign count_inc = (count_ff != srle_pkg::COUNT_MAX) ? count_ff + 16'd1 : count_ff;
   assign wave_all  = {wave_hi_ff, wave_lo_ff};
   assign pat_byte  = (expand_ff == srle_pkg::EX_WAVE) ? wave_all[{pidx_ff, 3'b000} +: 8]
                                                       : srle_pkg::inst_byte(pidx_ff);
   assign pidx_next = pidx_ff + PB'(1);

   // block index wraps through zero, so a seek byte of zero lands one block below
   assign block_idx  = OB'(b) - OB'(1);
   assign block_prod = block_idx * block_size_ff;
   assign seek_abs   = first_off_ff + block_prod[OB-1:0];
   assign seek_rel   = rpos_ff + OB'(block_size_ff);

   always_comb begin
      phase_in  = phase_ff;
      expand_in = expand_ff;
      reps_in   = reps_ff;
      pidx_in   = pidx_ff;
      run_in    = run_ff;
      rpos_in   = rpos_ff;
      count_in  = count_ff;
      res_vld   = 1'b0;
      res.kind    = srle_pkg::KIND_DATA;
      res.data    = 8'h00;
      res.seek    = '0;
      res.size_ok = 1'b0;

      if (item.is_tick) begin
         if (pending) begin
            res_vld  = 1'b1;
            count_in = count_inc;
            if (expand_ff == srle_pkg::EX_RUN) begin
               res.data = run_ff;
               reps_in  = reps_ff - 8'd1;
            end else begin
               res.data = pat_byte;
               pidx_in  = pidx_next;
               if (pidx_next == '0) begin
                  reps_in = reps_ff - 8'd1;
               end
            end
            if (reps_in == 8'd0) begin
               expand_in = srle_pkg::EX_NONE;
            end
         end
      end else if (pending) begin
         // byte during an expansion is dropped
         res_vld  = 1'b1;
         res.kind = srle_pkg::KIND_ERROR;
      end else begin
         unique case (phase_ff) inside
            srle_pkg::PH_RUN_VAL: begin
               if (b == srle_pkg::BYTE_RLE) begin
                  phase_in = srle_pkg::PH_IDLE;
                  count_in = count_inc;
                  res_vld  = 1'b1;
                  res.data = b;
               end else begin
                  run_in   = b;
                  phase_in = srle_pkg::PH_RUN_CNT;
               end
            end
            srle_pkg::PH_RUN_CNT, srle_pkg::PH_WAVE_CNT, srle_pkg::PH_INST_CNT: begin
               phase_in = srle_pkg::PH_IDLE;
               if (b == 8'd0) begin
                  expand_in = srle_pkg::EX_NONE;
                  reps_in   = 8'd0;
               end else begin
                  reps_in = b;
                  pidx_in = '0;
                  if (phase_ff == srle_pkg::PH_RUN_CNT) begin
                     expand_in = srle_pkg::EX_RUN;
                  end else if (phase_ff == srle_pkg::PH_WAVE_CNT) begin
                     expand_in = srle_pkg::EX_WAVE;
                  end else begin
                     expand_in = srle_pkg::EX_INST;
                  end
               end
            end
            srle_pkg::PH_ESC: begin
               phase_in = srle_pkg::PH_IDLE;
               if (b == srle_pkg::BYTE_SPEC) begin
                  count_in = count_inc;
                  res_vld  = 1'b1;
                  res.data = b;
               end else if (b == srle_pkg::BYTE_WAVE) begin
                  phase_in = srle_pkg::PH_WAVE_CNT;
               end else if (b == srle_pkg::BYTE_INST) begin
                  phase_in = srle_pkg::PH_INST_CNT;
               end else if (b == srle_pkg::BYTE_EOF) begin
                  res_vld     = 1'b1;
                  res.kind    = srle_pkg::KIND_END;
                  res.size_ok = (count_ff == srle_pkg::SONG_SIZE);
                  count_in    = 16'd0;
                  rpos_in     = start_off_ff;
               end else begin
                  rpos_in  = abs_mode_ff ? seek_abs : seek_rel;
                  res_vld  = 1'b1;
                  res.kind = srle_pkg::KIND_SEEK;
                  res.seek = rpos_in;
               end
            end
            default: begin
               phase_in = srle_pkg::PH_IDLE;
               if (b == srle_pkg::BYTE_RLE) begin
                  phase_in = srle_pkg::PH_RUN_VAL;
               end else if (b == srle_pkg::BYTE_SPEC) begin
                  phase_in = srle_pkg::PH_ESC;
               end else begin
                  count_in = count_inc;
                  res_vld  = 1'b1;
                  res.data = b;
               end
            end
         endcase
      end

      res.more = (expand_in != srle_pkg::EX_NONE) && (reps_in != 8'd0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= srle_pkg::PH_IDLE;
         expand_ff <= srle_pkg::EX_NONE;
         reps_ff   <= 8'd0;
         pidx_ff   <= '0;
         run_ff    <= 8'd0;
         count_ff  <= 16'd0;
      end else if (advance) begin
         phase_ff  <= phase_in;
         expand_ff <= expand_in;
         reps_ff   <= reps_in;
         pidx_ff   <= pidx_in;
         run_ff    <= run_in;
         count_ff  <= count_in;
      end
   end

   // read position: a start offset write reloads it
   always_ff @(posedge clock) begin
      if (reset) begin
         rpos_ff <= '0;
      end else if (csr_we && csr_index == srle_pkg::CSR_START_OFF) begin
         rpos_ff <= csr_wdata[OB-1:0];
      end else if (advance) begin
         rpos_ff <= rpos_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         abs_mode_ff   <= 1'b1;
         first_off_ff  <= '0;
         block_size_ff <= 16'd512;
         start_off_ff  <= '0;
         wave_lo_ff    <= 64'd0;
         wave_hi_ff    <= 64'd0;
      end else if (csr_we) begin
         unique case (csr_index)
            srle_pkg::CSR_ABS_MODE:   abs_mode_ff   <= csr_wdata[0];
            srle_pkg::CSR_FIRST_OFF:  first_off_ff  <= csr_wdata[OB-1:0];
            srle_pkg::CSR_BLOCK_SIZE: block_size_ff <= csr_wdata[15:0];
            srle_pkg::CSR_START_OFF:  start_off_ff  <= csr_wdata[OB-1:0];
            srle_pkg::CSR_WAVE_LO:    wave_lo_ff    <= csr_wdata;
            srle_pkg::CSR_WAVE_HI:    wave_hi_ff    <= csr_wdata;
            default: ;
         endcase
      end
   end

endmodule

// ----- rtl/srle_out_stage.sv -----
// ---------------------------------------------------------------------------
// srle_out_stage
// Result register toward the response channel.
// ---------------------------------------------------------------------------
module srle_out_stage (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              load,
   input  srle_pkg::result_type              res,
   output logic                              out_free,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [1:0]                        rsp_out_kind,
   output logic [7:0]                        rsp_out_byte,
   output logic [srle_pkg::OFFSET_BITS-1:0]  rsp_seek_offset,
   output logic                              rsp_size_ok,
   output logic                              rsp_more_pending
);

   logic                 vld_ff, vld_in;
   srle_pkg::result_type res_ff;

   assign out_free = !vld_ff || rsp_ready;
   assign vld_in   = load ? 1'b1 : (rsp_ready ? 1'b0 : vld_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         res_ff <= res;
      end
   end

   assign rsp_valid        = vld_ff;
   assign rsp_out_kind     = res_ff.kind;
   assign rsp_out_byte     = res_ff.data;
   assign rsp_seek_offset  = res_ff.seek;
   assign rsp_size_ok      = res_ff.size_ok;
   assign rsp_more_pending = res_ff.more;

endmodule

// ----- tb/song_decode_checker.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// song_decode_checker
// Watches the request, result and register ports of the song block RLE
// decoder, predicts every result from its own copy of the parser state and
// compares each result transfer field by field against the oldest prediction.
// ---------------------------------------------------------------------------
module song_decode_checker (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   input  logic                              req_ready,
   input  logic                              req_type,
   input  logic [7:0]                        req_in_byte,
   input  logic                              rsp_valid,
   input  logic                              rsp_ready,
   input  logic [1:0]                        rsp_out_kind,
   input  logic [7:0]                        rsp_out_byte,
   input  logic [srle_pkg::OFFSET_BITS-1:0]  rsp_seek_offset,
   input  logic                              rsp_size_ok,
   input  logic                              rsp_more_pending,
   input  logic                              csr_we,
   input  logic [srle_pkg::CSR_IDX_BITS-1:0] csr_index,
   input  logic [63:0]                       csr_wdata,
   output int                                fail_count,
   output int                                outstanding
);

   localparam int OB = srle_pkg::OFFSET_BITS;

   // default instrument, byte 0 in the low bits
   localparam logic [127:0] INST_PATTERN = 128'h0000F300_0000D000_00030000_FF0000A8;

   // register copy
   logic          abs_mode;
   logic [OB-1:0] first_off;
   logic [15:0]   blk_size;
   logic [OB-1:0] start_off;
   logic [63:0]   wave_lo;
   logic [63:0]   wave_hi;

   // parser copy
   srle_pkg::phase_type  phase;
   srle_pkg::expand_type expand;
   logic [7:0]           repeats;
   logic [3:0]           pidx;
   logic [7:0]           run_byte;
   logic [OB-1:0]        read_pos;
   logic [15:0]          produced;

   srle_pkg::result_type expected_results[$];

   function automatic bit expansion_pending();
      return (expand != srle_pkg::EX_NONE) && (repeats != 8'd0);
   endfunction

   task automatic count_byte();
      if (produced != srle_pkg::COUNT_MAX)
         produced = produced + 16'd1;
   endtask

   task automatic start_expansion(input srle_pkg::expand_type kind,
                                  input logic [7:0] count);
      phase = srle_pkg::PH_IDLE;
      if (count == 8'd0) begin
         expand  = srle_pkg::EX_NONE;
         repeats = 8'd0;
      end else begin
         expand  = kind;
         repeats = count;
         pidx    = 4'd0;
      end
   endtask

   task automatic decode_item(input logic tick, input logic [7:0] b,
                              output bit hit, output srle_pkg::result_type r);
      logic [7:0]   v;
      logic [127:0] wave;
      logic [31:0]  idx_m1;
      logic [63:0]  prod;
      hit  = 1'b0;
      r    = '0;
      wave = {wave_hi, wave_lo};
      if (tick) begin
         if (expansion_pending()) begin
            if (expand == srle_pkg::EX_RUN) begin
               v       = run_byte;
               repeats = repeats - 8'd1;
            end else begin
               v    = (expand == srle_pkg::EX_WAVE) ? wave[8*pidx +: 8]
                                                    : INST_PATTERN[8*pidx +: 8];
               pidx = pidx + 4'd1;
               // a whole pattern copy is done once the index wraps
               if (pidx == 4'd0)
                  repeats = repeats - 8'd1;
            end
            if (repeats == 8'd0)
               expand = srle_pkg::EX_NONE;
            count_byte();
            hit    = 1'b1;
            r.kind = srle_pkg::KIND_DATA;
            r.data = v;
         end
      end else if (expansion_pending()) begin
         // byte dropped, state kept
         hit    = 1'b1;
         r.kind = srle_pkg::KIND_ERROR;
      end else begin
         case (phase)
            srle_pkg::PH_RUN_VAL: begin
               if (b == srle_pkg::BYTE_RLE) begin
                  phase = srle_pkg::PH_IDLE;
                  count_byte();
                  hit    = 1'b1;
                  r.kind = srle_pkg::KIND_DATA;
                  r.data = b;
               end else begin
                  run_byte = b;
                  phase    = srle_pkg::PH_RUN_CNT;
               end
            end
            srle_pkg::PH_RUN_CNT:  start_expansion(srle_pkg::EX_RUN, b);
            srle_pkg::PH_WAVE_CNT: start_expansion(srle_pkg::EX_WAVE, b);
            srle_pkg::PH_INST_CNT: start_expansion(srle_pkg::EX_INST, b);
            srle_pkg::PH_ESC: begin
               phase = srle_pkg::PH_IDLE;
               if (b == srle_pkg::BYTE_SPEC) begin
                  count_byte();
                  hit    = 1'b1;
                  r.kind = srle_pkg::KIND_DATA;
                  r.data = b;
               end else if (b == srle_pkg::BYTE_WAVE) begin
                  phase = srle_pkg::PH_WAVE_CNT;
               end else if (b == srle_pkg::BYTE_INST) begin
                  phase = srle_pkg::PH_INST_CNT;
               end else if (b == srle_pkg::BYTE_EOF) begin
                  hit       = 1'b1;
                  r.kind    = srle_pkg::KIND_END;
                  r.size_ok = (produced == srle_pkg::SONG_SIZE);
                  produced  = 16'd0;
                  read_pos  = start_off;
               end else begin
                  if (abs_mode) begin
                     // index zero wraps to minus one block
                     idx_m1   = {24'd0, b} - 32'd1;
                     prod     = idx_m1 * blk_size;
                     read_pos = first_off + prod[OB-1:0];
                  end else begin
                     read_pos = read_pos + {8'd0, blk_size};
                  end
                  hit    = 1'b1;
                  r.kind = srle_pkg::KIND_SEEK;
                  r.seek = read_pos;
               end
            end
            default: begin
               phase = srle_pkg::PH_IDLE;
               if (b == srle_pkg::BYTE_RLE) begin
                  phase = srle_pkg::PH_RUN_VAL;
               end else if (b == srle_pkg::BYTE_SPEC) begin
                  phase = srle_pkg::PH_ESC;
               end else begin
                  count_byte();
                  hit    = 1'b1;
                  r.kind = srle_pkg::KIND_DATA;
                  r.data = b;
               end
            end
         endcase
      end
      if (hit)
         r.more = expansion_pending();
   endtask

   always @(posedge clock) begin
      bit                   hit;
      srle_pkg::result_type pred;
      srle_pkg::result_type exp_r;
      if (reset) begin
         abs_mode   = 1'b1;
         first_off  = '0;
         blk_size   = 16'd512;
         start_off  = '0;
         wave_lo    = '0;
         wave_hi    = '0;
         phase      = srle_pkg::PH_IDLE;
         expand     = srle_pkg::EX_NONE;
         repeats    = '0;
         pidx       = '0;
         run_byte   = '0;
         read_pos   = '0;
         produced   = '0;
         fail_count = 0;
         expected_results.delete();
      end else begin
         // a result never leaves in the cycle its request arrives
         if (rsp_valid && rsp_ready) begin
            if (expected_results.size() == 0) begin
               $error("unexpected result transfer: out_kind %0d", rsp_out_kind);
               fail_count++;
            end else begin
               exp_r = expected_results.pop_front();
               if (rsp_out_kind !== exp_r.kind) begin
                  $error("out_kind: expected %0d, actual %0d", exp_r.kind, rsp_out_kind);
                  fail_count++;
               end
               if (rsp_out_byte !== exp_r.data) begin
                  $error("out_byte: expected %0h, actual %0h", exp_r.data, rsp_out_byte);
                  fail_count++;
               end
               if (rsp_seek_offset !== exp_r.seek) begin
                  $error("seek_offset: expected %0h, actual %0h", exp_r.seek,
                         rsp_seek_offset);
                  fail_count++;
               end
               if (rsp_size_ok !== exp_r.size_ok) begin
                  $error("size_ok: expected %0b, actual %0b", exp_r.size_ok, rsp_size_ok);
                  fail_count++;
               end
               if (rsp_more_pending !== exp_r.more) begin
                  $error("more_pending: expected %0b, actual %0b", exp_r.more,
                         rsp_more_pending);
                  fail_count++;
               end
            end
         end
         if (csr_we) begin
            case (csr_index)
               srle_pkg::CSR_ABS_MODE:   abs_mode  = csr_wdata[0];
               srle_pkg::CSR_FIRST_OFF:  first_off = csr_wdata[OB-1:0];
               srle_pkg::CSR_BLOCK_SIZE: blk_size  = csr_wdata[15:0];
               srle_pkg::CSR_START_OFF: begin
                  start_off = csr_wdata[OB-1:0];
                  read_pos  = csr_wdata[OB-1:0];
               end
               srle_pkg::CSR_WAVE_LO:    wave_lo   = csr_wdata;
               srle_pkg::CSR_WAVE_HI:    wave_hi   = csr_wdata;
               default: ;
            endcase
         end
         if (req_valid && req_ready) begin
            decode_item(req_type, req_in_byte, hit, pred);
            if (hit)
               expected_results.push_back(pred);
         end
      end
      outstanding = expected_results.size();
   end

endmodule

// ----- tb/tb_song_block_rle_decompressor.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_song_block_rle_decompressor
// Drives compressed song bytes and drain ticks into the decoder with random
// gaps and result stalls, over several register settings; the checker beside
// the block predicts and compares, this module gives the verdict.
// ---------------------------------------------------------------------------
module tb_song_block_rle_decompressor;

   localparam logic REQ_BYTE      = 1'b0;
   localparam logic REQ_TICK      = 1'b1;
   localparam int   GAP_MAX       = 6;
   localparam int   SETTLE_CYCLES = 8;    // pipeline is two deep, leave margin
   localparam int   RANDOM_ITEMS  = 450;  // per random phase, four phases

   logic                              clock;
   logic                              reset;
   logic                              req_valid;
   logic                              req_ready;
   logic                              req_type;
   logic [7:0]                        req_in_byte;
   logic                              rsp_valid;
   logic                              rsp_ready;
   logic [1:0]                        rsp_out_kind;
   logic [7:0]                        rsp_out_byte;
   logic [srle_pkg::OFFSET_BITS-1:0]  rsp_seek_offset;
   logic                              rsp_size_ok;
   logic                              rsp_more_pending;
   logic                              csr_we;
   logic [srle_pkg::CSR_IDX_BITS-1:0] csr_index;
   logic [63:0]                       csr_wdata;

   int fail_count;
   int outstanding;

   // sender and receiver state; quiet and hold_req are shared between them
   bit quiet;          // no gaps and no stalls while set
   int hold_req;       // receiver holds ready low this many cycles, once
   int items_sent;
   int drain_owed;     // bytes the sender believes are queued

   song_block_rle_decompressor DUT (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_type         (req_type),
      .req_in_byte      (req_in_byte),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_out_kind     (rsp_out_kind),
      .rsp_out_byte     (rsp_out_byte),
      .rsp_seek_offset  (rsp_seek_offset),
      .rsp_size_ok      (rsp_size_ok),
      .rsp_more_pending (rsp_more_pending),
      .csr_we           (csr_we),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata)
   );

   song_decode_checker decode_check (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_type         (req_type),
      .req_in_byte      (req_in_byte),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_out_kind     (rsp_out_kind),
      .rsp_out_byte     (rsp_out_byte),
      .rsp_seek_offset  (rsp_seek_offset),
      .rsp_size_ok      (rsp_size_ok),
      .rsp_more_pending (rsp_more_pending),
      .csr_we           (csr_we),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .fail_count       (fail_count),
      .outstanding      (outstanding)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // Hard stop.
   initial begin
      #2_000_000;
      $display("CHECK FAILED");
      $finish;
   end

   // -----------------------------------------------------------------------
   // Sender side
   // -----------------------------------------------------------------------

   // One request transfer. Everything changes at the falling edge; the
   // transfer is seen at the rising edge where valid and ready are both high.
   // With no gap, valid simply stays high into the next item.
   task automatic send_item(input logic tick, input logic [7:0] b);
      int gap;
      gap = quiet ? 0 : $urandom_range(0, GAP_MAX);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid   <= 1'b1;
      req_type    <= tick;
      req_in_byte <= b;
      do @(posedge clock); while (!req_ready);
      @(negedge clock);
      items_sent++;
      if (tick && drain_owed > 0)
         drain_owed--;
   endtask

   // drain ticks carry a random byte that the block must ignore
   task automatic drain(input int n);
      repeat (n) send_item(REQ_TICK, 8'($urandom));
   endtask

   // three-byte expansion command: run (C0 v n), wave or instrument (E0 sel n)
   task automatic queue_cmd(input logic [7:0] lead, input logic [7:0] sel,
                            input logic [7:0] count);
      send_item(REQ_BYTE, lead);
      send_item(REQ_BYTE, sel);
      send_item(REQ_BYTE, count);
      drain_owed += (lead == srle_pkg::BYTE_RLE) ? int'(count) : 16 * int'(count);
   endtask

   // two-byte escape: E0 x
   task automatic send_escape(input logic [7:0] x);
      send_item(REQ_BYTE, srle_pkg::BYTE_SPEC);
      send_item(REQ_BYTE, x);
   endtask

   // Quiet point: drop valid, wait for every predicted result, then give
   // the block time to finish items that make no result.
   task automatic settle();
      req_valid <= 1'b0;
      while (outstanding != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   // Writes all six registers back to back; called only at quiet points, after reset or settle().
   task automatic program_regs(input logic am, input logic [23:0] fo,
                               input logic [15:0] bs, input logic [23:0] so,
                               input logic [63:0] wl, input logic [63:0] wh);
      csr_we    <= 1'b1;
      csr_index <= srle_pkg::CSR_ABS_MODE;
      csr_wdata <= {63'd0, am};
      @(negedge clock);
      csr_index <= srle_pkg::CSR_FIRST_OFF;
      csr_wdata <= {40'd0, fo};
      @(negedge clock);
      csr_index <= srle_pkg::CSR_BLOCK_SIZE;
      csr_wdata <= {48'd0, bs};
      @(negedge clock);
      csr_index <= srle_pkg::CSR_START_OFF;
      csr_wdata <= {40'd0, so};
      @(negedge clock);
      csr_index <= srle_pkg::CSR_WAVE_LO;
      csr_wdata <= wl;
      @(negedge clock);
      csr_index <= srle_pkg::CSR_WAVE_HI;
      csr_wdata <= wh;
      @(negedge clock);
      csr_we    <= 1'b0;
      @(negedge clock);
   endtask

   // Mostly well-formed command sequences with random content, some noise.
   // While the sender thinks bytes are queued it mostly drains, sometimes
   // pushes a byte in to hit the overrun path.
   task automatic random_phase(input int n_items);
      int         target;
      int         pick;
      logic [7:0] b;
      logic [7:0] cnt;
      target = items_sent + n_items;
      while (items_sent < target) begin
         pick = $urandom_range(0, 99);
         if ($urandom_range(0, 49) == 0)
            quiet = ~quiet;
         if (drain_owed > 0) begin
            if (pick < 92)
               drain(1);
            else
               send_item(REQ_BYTE, 8'($urandom));
         end else if (pick < 35) begin
            b = 8'($urandom);
            if (b == srle_pkg::BYTE_RLE || b == srle_pkg::BYTE_SPEC)
               b = b ^ 8'h01;
            send_item(REQ_BYTE, b);
         end else if (pick < 50) begin
            b   = 8'($urandom);
            cnt = ($urandom_range(0, 9) == 0) ? 8'($urandom) : 8'($urandom_range(0, 6));
            if (b == srle_pkg::BYTE_RLE) begin
               send_item(REQ_BYTE, srle_pkg::BYTE_RLE);
               send_item(REQ_BYTE, srle_pkg::BYTE_RLE);
            end else begin
               queue_cmd(srle_pkg::BYTE_RLE, b, cnt);
            end
         end else if (pick < 55) begin
            send_item(REQ_BYTE, srle_pkg::BYTE_RLE);
            send_item(REQ_BYTE, srle_pkg::BYTE_RLE);
         end else if (pick < 60) begin
            send_escape(srle_pkg::BYTE_SPEC);
         end else if (pick < 78) begin
            cnt = ($urandom_range(0, 19) == 0) ? 8'($urandom_range(4, 16))
                                               : 8'($urandom_range(0, 3));
            queue_cmd(srle_pkg::BYTE_SPEC,
                      (pick < 70) ? srle_pkg::BYTE_WAVE : srle_pkg::BYTE_INST, cnt);
         end else if (pick < 91) begin
            b = 8'($urandom);
            if (b == srle_pkg::BYTE_SPEC || b == srle_pkg::BYTE_WAVE ||
                b == srle_pkg::BYTE_INST || b == srle_pkg::BYTE_EOF)
               b = b ^ 8'h02;
            send_escape(b);
         end else if (pick < 94) begin
            send_escape(srle_pkg::BYTE_EOF);
         end else begin
            send_item(1'($urandom), 8'($urandom));
         end
      end
      quiet = 1'b0;
   endtask

   // -----------------------------------------------------------------------
   // Receiver side: random stall per result, plus one long hold-off on
   // request, counted here in its own cycles.
   // -----------------------------------------------------------------------
   initial begin
      int stall;
      int n;
      rsp_ready = 1'b0;
      @(negedge reset);
      forever begin
         if (hold_req > 0) begin
            n        = hold_req;
            hold_req = 0;
            rsp_ready <= 1'b0;
            repeat (n) @(negedge clock);
         end
         stall = quiet ? 0 : $urandom_range(0, GAP_MAX);
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!rsp_valid);
         @(negedge clock);
      end
   end

   // -----------------------------------------------------------------------
   // Stimulus and verdict
   // -----------------------------------------------------------------------
   initial begin
      reset       = 1'b1;
      req_valid   = 1'b0;
      req_type    = REQ_BYTE;
      req_in_byte = 8'h00;
      csr_we      = 1'b0;
      csr_index   = srle_pkg::CSR_ABS_MODE;
      csr_wdata   = 64'd0;
      quiet       = 1'b0;
      hold_req    = 0;
      items_sent  = 0;
      drain_owed  = 0;
      repeat (4) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed: absolute seeks, distinct wave bytes so index errors show
      program_regs(1'b1, 24'h001000, 16'h0200, 24'h000000,
                   64'h0706050403020100, 64'h0F0E0D0C0B0A0908);
      send_item(REQ_BYTE, 8'h00);
      send_item(REQ_BYTE, 8'hFF);
      send_item(REQ_BYTE, 8'h5A);
      send_item(REQ_BYTE, srle_pkg::BYTE_RLE);       // escaped C0
      send_item(REQ_BYTE, srle_pkg::BYTE_RLE);
      queue_cmd(srle_pkg::BYTE_RLE, 8'h77, 8'd3);
      drain(4);                                      // last tick finds nothing queued
      queue_cmd(srle_pkg::BYTE_RLE, 8'h11, 8'd0);    // zero count queues nothing
      send_escape(srle_pkg::BYTE_SPEC);              // escaped E0
      queue_cmd(srle_pkg::BYTE_SPEC, srle_pkg::BYTE_WAVE, 8'd1);
      send_item(REQ_BYTE, 8'h42);                    // byte during expansion: overrun
      drain(16);
      queue_cmd(srle_pkg::BYTE_SPEC, srle_pkg::BYTE_INST, 8'd1);
      drain(16);
      send_escape(8'h00);                            // block index zero wraps
      send_escape(8'h01);
      send_escape(8'hFE);
      send_escape(srle_pkg::BYTE_EOF);
      settle();

      // directed: relative seeks with block size zero, then offset wrap
      program_regs(1'b0, 24'h000000, 16'h0000, 24'hFFFF00, 64'd0, 64'd0);
      send_escape(8'h05);                            // zero block size: no move
      settle();
      program_regs(1'b0, 24'hFFFFFF, 16'hFFFF, 24'hFFFFFF, '1, '1);
      send_escape(8'h07);
      send_escape(8'h07);
      send_escape(srle_pkg::BYTE_EOF);               // reloads read position
      send_escape(8'h07);

      // backpressure: receiver holds off long while the sender keeps offering
      quiet    = 1'b1;
      hold_req = 250;
      repeat (40) send_item(REQ_BYTE, 8'($urandom_range(1, 8'hBF)));
      quiet = 1'b0;
      settle();                                      // sender waits for all results

      // random phases: minimum block, maxima, then two random settings
      program_regs(1'b1, 24'h000000, 16'd1, 24'h000000, 64'd0, 64'd0);
      random_phase(RANDOM_ITEMS);
      settle();
      program_regs(1'b0, 24'hFFFFFF, 16'hFFFF, 24'hFFFFFF, '1, '1);
      random_phase(RANDOM_ITEMS);
      settle();
      program_regs(1'b1, 24'($urandom), 16'($urandom_range(1, 65535)), 24'($urandom),
                   {$urandom, $urandom}, {$urandom, $urandom});
      random_phase(RANDOM_ITEMS);
      settle();
      program_regs(1'b0, 24'($urandom), 16'($urandom_range(1, 65535)), 24'($urandom),
                   {$urandom, $urandom}, {$urandom, $urandom});
      random_phase(RANDOM_ITEMS);
      settle();

      if (fail_count == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

endmodule

// ----- files.f -----
rtl/srle_pkg.sv
rtl/srle_in_stage.sv
rtl/srle_core.sv
rtl/srle_out_stage.sv
rtl/song_block_rle_decompressor.sv
tb/song_decode_checker.sv
tb/tb_song_block_rle_decompressor.sv
